[hdl/des_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the directory entry scanner.
// No dependencies; imported by every module of the block.
package des_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_SCAN_MODE      = 3'd0;
   localparam logic [2:0] CSR_ARCHIVE_SIZE   = 3'd1;
   localparam logic [2:0] CSR_PRIMARY_NAME   = 3'd2;
   localparam logic [2:0] CSR_SECONDARY_NAME = 3'd3;
   localparam logic [2:0] CSR_FLAT_ORDINAL   = 3'd4;

   // scan modes
   localparam logic [2:0] MODE_FIND_LUMP   = 3'd0;
   localparam logic [2:0] MODE_FIND_MAP    = 3'd1;
   localparam logic [2:0] MODE_MAP_LUMP    = 3'd2;
   localparam logic [2:0] MODE_GET_FLAT    = 3'd3;
   localparam logic [2:0] MODE_COUNT_FLATS = 3'd4;

   // result status codes
   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_OOB       = 2'd2;

   // marker names, eight bytes zero padded, byte 0 lowest
   localparam logic [63:0] NAME_F_START = 64'h0054_5241_5453_5F46;
   localparam logic [63:0] NAME_F_END   = 64'h0000_0044_4E45_5F46;

   // result queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [31:0] flat_total;
      logic [63:0] found_name;
      logic [31:0] found_size;
      logic [31:0] found_offset;
      logic [31:0] found_index;
      logic [1:0]  status;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type res;
   } push_type;

endpackage

[hdl/des_front.sv]
`timescale 1ns / 1ps
// Front end: configuration registers, entry classification and scan state.
// Depends on des_pkg; pushes at most one result per accepted entry.
module des_front #(
   parameter int MAP_WINDOW = 11,
   parameter int FLAT_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata,
   input  logic               entry_accept,
   input  logic [31:0]        entry_offset,
   input  logic [31:0]        entry_size,
   input  logic [63:0]        entry_name,
   input  logic               last_entry,
   output des_pkg::push_type  push_out
);
   import des_pkg::*;

   localparam logic [31:0] WINDOW_LEN = 32'(MAP_WINDOW);
   localparam logic [31:0] FLAT_LEN   = 32'(FLAT_BYTES);

   logic [2:0]  scan_mode_ff;
   logic [31:0] archive_size_ff;
   logic [63:0] primary_name_ff;
   logic [63:0] secondary_name_ff;
   logic [31:0] flat_ordinal_ff;

   logic [31:0] entry_counter_ff, entry_counter_in;
   logic        inside_flats_ff, inside_flats_in;
   logic        marker_seen_ff, marker_seen_in;
   logic [31:0] marker_index_ff, marker_index_in;
   logic [31:0] flats_seen_ff, flats_seen_in;
   logic        scan_done_ff, scan_done_in;

   logic        prim_hit, sec_hit, fstart_hit, fend_hit;
   logic        lump_ok, flat_ok, in_window;
   logic [31:0] marker_gap;
   logic        hit;
   result_type  res;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_mode_ff      <= MODE_FIND_LUMP;
         archive_size_ff   <= '0;
         primary_name_ff   <= '0;
         secondary_name_ff <= '0;
         flat_ordinal_ff   <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SCAN_MODE:      scan_mode_ff      <= csr_wdata[2:0];
            CSR_ARCHIVE_SIZE:   archive_size_ff   <= csr_wdata[31:0];
            CSR_PRIMARY_NAME:   primary_name_ff   <= csr_wdata;
            CSR_SECONDARY_NAME: secondary_name_ff <= csr_wdata;
            CSR_FLAT_ORDINAL:   flat_ordinal_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // per-entry compares and bounds checks
   assign prim_hit   = (entry_name == primary_name_ff);
   assign sec_hit    = (entry_name == secondary_name_ff);
   assign fstart_hit = (entry_name == NAME_F_START);
   assign fend_hit   = (entry_name == NAME_F_END);
   assign lump_ok    = (entry_size <= archive_size_ff) &&
                       (entry_offset <= archive_size_ff - entry_size);
   assign flat_ok    = (entry_size == FLAT_LEN) && (FLAT_LEN <= archive_size_ff) &&
                       (entry_offset <= archive_size_ff - FLAT_LEN);
   assign marker_gap = entry_counter_ff - marker_index_ff;
   assign in_window  = (marker_gap != '0) && (marker_gap <= WINDOW_LEN);

   // decision and next scan state
   always_comb begin
      hit              = 1'b0;
      res              = '0;
      res.found_index  = entry_counter_ff;
      inside_flats_in  = inside_flats_ff;
      marker_seen_in   = marker_seen_ff;
      marker_index_in  = marker_index_ff;
      flats_seen_in    = flats_seen_ff;
      scan_done_in     = scan_done_ff;
      entry_counter_in = entry_counter_ff;

      if (entry_accept) begin
         if (!scan_done_ff) begin
            case (scan_mode_ff)
               MODE_FIND_LUMP: begin
                  if (prim_hit) begin
                     hit              = 1'b1;
                     res.status       = lump_ok ? ST_FOUND : ST_OOB;
                     res.found_offset = entry_offset;
                     res.found_size   = entry_size;
                     res.found_name   = entry_name;
                  end
               end
               MODE_FIND_MAP: begin
                  if (prim_hit) begin
                     hit              = 1'b1;
                     res.status       = ST_FOUND;
                     res.found_offset = entry_offset;
                     res.found_size   = entry_size;
                     res.found_name   = entry_name;
                  end
               end
               MODE_MAP_LUMP: begin
                  if (!marker_seen_ff) begin
                     if (prim_hit) begin
                        marker_seen_in  = 1'b1;
                        marker_index_in = entry_counter_ff;
                     end
                  end else if (in_window && sec_hit) begin
                     hit              = 1'b1;
                     res.status       = lump_ok ? ST_FOUND : ST_OOB;
                     res.found_offset = entry_offset;
                     res.found_size   = entry_size;
                     res.found_name   = entry_name;
                  end else if (!in_window || marker_gap == WINDOW_LEN) begin
                     hit        = 1'b1;
                     res.status = ST_NOT_FOUND;
                  end
               end
               MODE_GET_FLAT, MODE_COUNT_FLATS: begin
                  priority if (fstart_hit) begin
                     inside_flats_in = 1'b1;
                  end else if (fend_hit) begin
                     hit = 1'b1;
                     if (scan_mode_ff == MODE_COUNT_FLATS) begin
                        res.status     = ST_FOUND;
                        res.flat_total = flats_seen_ff;
                     end else begin
                        res.status = ST_NOT_FOUND;
                     end
                  end else if (inside_flats_ff && flat_ok) begin
                     if (scan_mode_ff == MODE_GET_FLAT && flats_seen_ff == flat_ordinal_ff) begin
                        hit              = 1'b1;
                        res.status       = ST_FOUND;
                        res.found_offset = entry_offset;
                        res.found_size   = entry_size;
                        res.found_name   = entry_name;
                     end else begin
                        flats_seen_in = flats_seen_ff + 32'd1;
                     end
                  end
               end
               default: ;
            endcase

            // undecided at the last entry
            if (!hit && last_entry) begin
               hit = 1'b1;
               if (scan_mode_ff == MODE_COUNT_FLATS) begin
                  res.status     = ST_FOUND;
                  res.flat_total = flats_seen_in;
               end else begin
                  res.status = ST_NOT_FOUND;
               end
            end
            if (hit) begin
               scan_done_in = 1'b1;
            end
         end

         // end of directory clears the scan
         if (last_entry) begin
            entry_counter_in = '0;
            inside_flats_in  = 1'b0;
            marker_seen_in   = 1'b0;
            marker_index_in  = '0;
            flats_seen_in    = '0;
            scan_done_in     = 1'b0;
         end else begin
            entry_counter_in = entry_counter_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_counter_ff <= '0;
         inside_flats_ff  <= 1'b0;
         marker_seen_ff   <= 1'b0;
         marker_index_ff  <= '0;
         flats_seen_ff    <= '0;
         scan_done_ff     <= 1'b0;
      end else begin
         entry_counter_ff <= entry_counter_in;
         inside_flats_ff  <= inside_flats_in;
         marker_seen_ff   <= marker_seen_in;
         marker_index_ff  <= marker_index_in;
         flats_seen_ff    <= flats_seen_in;
         scan_done_ff     <= scan_done_in;
      end
   end

   assign push_out.push = hit;
   assign push_out.res  = res;

endmodule

[hdl/des_queue.sv]
`timescale 1ns / 1ps
// Short result queue between the front end and the output stage.
// Depends on des_pkg for the result type and depth.
module des_queue (
   input  logic                clock,
   input  logic                reset,
   input  des_pkg::push_type   push_in,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output des_pkg::result_type head
);
   import des_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   result_type         slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     count_ff, count_in;

   assign full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   // storage, no reset on payload
   always_ff @(posedge clock) begin
      if (push_in.push) begin
         slots_ff[wr_ptr_ff] <= push_in.res;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push_in.push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (!push_in.push && pop) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_in.push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

[hdl/des_back.sv]
`timescale 1ns / 1ps
// Output stage: pulls results from the queue into the response register.
// Depends on des_pkg for the result type.
module des_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  des_pkg::result_type q_head,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [199:0]        rsp_tdata
);
   import des_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // refill when the register is empty or its beat is taken
   assign q_pop = !q_empty && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= q_head;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, data_ff.flat_total, data_ff.found_name, data_ff.found_size,
                        data_ff.found_offset, data_ff.found_index, data_ff.status};

endmodule

[hdl/directory_entry_scanner_top.sv]
`timescale 1ns / 1ps
// Directory entry scanner: scans an archive directory, one 16-byte entry a beat.
// Top level; instantiates des_front, des_queue and des_back; uses des_pkg.
//
// Usage:
//  - Configure scan mode, archive size, names and flat ordinal through the
//    csr_ write port while the block is idle (one register per cycle).
//  - Stream directory entries on req_; req_tlast marks the final entry.
//  - Each scan yields at most one response beat on rsp_; further entries of
//    that directory are consumed without a result until req_tlast.
// Throughput: one entry per cycle while req_tready is high; the front end
//  decides each entry combinationally (64-bit name compares and a 32-bit bounds subtract).
// Path: the deciding entry is written into the queue, then moved into the
//  response register that drives rsp_tvalid.
// Stall: results wait in a four-deep queue plus the response register;
//  req_tready drops only while the queue is full.
// Reset: synchronous; clears control and configuration registers to zero (not
//  queue slots or response data), empties the queue and zeroes the entry index.
module directory_entry_scanner_top #(
   parameter int MAP_WINDOW = 11,
   parameter int FLAT_BYTES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   // entry beats
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // entry_offset[31:0], entry_size[63:32],
                                    // entry_name[127:64]
   input  logic         req_tlast,  // last_entry
   // result beats
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata   // status[1:0], found_index[33:2],
                                    // found_offset[65:34], found_size[97:66],
                                    // found_name[161:98], flat_total[193:162]
);
   import des_pkg::*;

   logic       q_full, q_empty, q_pop;
   logic       entry_accept;
   push_type   push;
   result_type q_head;

   assign req_tready   = !q_full;
   assign entry_accept = req_tvalid && req_tready;

   des_front #(
      .MAP_WINDOW (MAP_WINDOW),
      .FLAT_BYTES (FLAT_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .entry_accept (entry_accept),
      .entry_offset (req_tdata[31:0]),
      .entry_size   (req_tdata[63:32]),
      .entry_name   (req_tdata[127:64]),
      .last_entry   (req_tlast),
      .push_out     (push)
   );

   des_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (q_pop),
      .full    (q_full),
      .empty   (q_empty),
      .head    (q_head)
   );

   des_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
